// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rcs assertion failed");
`define RCS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
        else $error("rcs assertion failed");
`else
`define RCS_ASSERT(lbl, prop)
`define RCS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- rtl/rcs_pkg.sv -----
package rcs_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int MAX_SAMPLES = 65536;
    localparam int CNT_W       = 17;
    localparam int SUM_W       = 24;
    localparam int SQ_W        = 33;
    localparam int Q_W         = 34;
    localparam int DIV_W       = 50;
    localparam int DVS_W       = 17;
    localparam int DIV_CNT_W   = 6;
    localparam int ROOT_W      = 25;
    localparam int ROOT_CNT_W  = 5;
    localparam int VAR_W       = 25;
    localparam int SD_W        = 17;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0]       sum;
        logic [SQ_W-1:0]        sq;
        logic [SAMPLE_BITS-1:0] mn;
        logic [SAMPLE_BITS-1:0] mx;
    } lane_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_PROD,
        ST_QSUM,
        ST_QFIN,
        ST_VAR,
        ST_VAR_WAIT,
        ST_SQRT_WAIT,
        ST_OUT
    } post_state_t;

endpackage

// ----- rtl/rcs_lane.sv -----
module rcs_lane
    import rcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   first,
    input  logic                   clear,
    input  logic [SAMPLE_BITS-1:0] sample,
    output lane_stat_t             stat_next
);

    lane_stat_t                stat_reg;
    logic [2*SAMPLE_BITS-1:0]  sq_term;

    assign sq_term = sample * sample;

    always_comb
    begin
        stat_next = stat_reg;
        if (en)
        begin
            if (first)
            begin
                stat_next.mn = sample;
                stat_next.mx = sample;
            end
            else
            begin
                if (sample < stat_reg.mn)
                begin
                    stat_next.mn = sample;
                end
                if (sample > stat_reg.mx)
                begin
                    stat_next.mx = sample;
                end
            end
            stat_next.sum = stat_reg.sum + SUM_W'(sample);
            stat_next.sq  = stat_reg.sq + SQ_W'(sq_term);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else if (clear)
        begin
            stat_reg <= '0;
        end
        else
        begin
            stat_reg <= stat_next;
        end
    end

endmodule

// ----- rtl/rcs_div.sv -----
module rcs_div
    import rcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DVS_W:0]       trial;
    logic                 ge;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

endmodule

// ----- rtl/rcs_sqrt.sv -----
module rcs_sqrt
    import rcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    localparam int REM_W = ROOT_W + 1;
    localparam int R2_W  = REM_W + 2;

    logic [DIV_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [R2_W-1:0]       r2;
    logic [R2_W-1:0]       trial;
    logic                  ge;

    assign r2    = {rem_reg, rad_reg[DIV_W-1:DIV_W-2]};
    assign trial = R2_W'({root_reg, 2'b01});
    assign ge    = r2 >= trial;
    assign root  = root_reg;
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ROOT_CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[DIV_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/rcs_post.sv -----
module rcs_post
    import rcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  lane_stat_t             stat_r,
    input  lane_stat_t             stat_g,
    input  lane_stat_t             stat_b,
    input  logic [CNT_W-1:0]       count,
    input  logic                   dropped,
    output logic                   idle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             channel,
    output logic [SAMPLE_BITS-1:0] mean,
    output logic [SAMPLE_BITS-1:0] minimum,
    output logic [SAMPLE_BITS-1:0] maximum,
    output logic [SAMPLE_BITS-1:0] spread,
    output logic [VAR_W-1:0]       variance_fx,
    output logic [SD_W-1:0]        std_dev_fx,
    output logic [CNT_W-1:0]       sample_count,
    output logic                   too_few,
    output logic                   overflowed,
    output logic                   end_of_set
);

    post_state_t            st_reg, st_next;
    lane_stat_t             snap_reg [3];
    logic [CNT_W-1:0]       n_reg;
    logic                   drop_reg;
    logic [1:0]             ch_reg, ch_next;
    logic [SAMPLE_BITS-1:0] m_reg, m_next;
    logic [31:0]            p1_reg, p1_next;
    logic [15:0]            p2_reg, p2_next;
    logic [32:0]            p3_reg, p3_next;
    logic [Q_W-1:0]         qa_reg, qa_next;
    logic [Q_W-1:0]         q_reg, q_next;
    logic [VAR_W-1:0]       var_reg, var_next;
    logic [SD_W-1:0]        sd_reg, sd_next;
    lane_stat_t             cur;
    logic                   few;
    logic                   empty;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [DVS_W-1:0]       div_divisor;
    logic [DIV_W-1:0]       div_quo;
    logic                   div_done;
    logic                   sqrt_start;
    logic [ROOT_W-1:0]      sqrt_root;
    logic                   sqrt_done;

    assign cur   = snap_reg[ch_reg];
    assign few   = n_reg < CNT_W'(2);
    assign empty = n_reg == '0;

    rcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    rcs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_quo),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    always_comb
    begin
        st_next      = st_reg;
        ch_next      = ch_reg;
        m_next       = m_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        p3_next      = p3_reg;
        qa_next      = qa_reg;
        q_next       = q_reg;
        var_next     = var_reg;
        sd_next      = sd_reg;
        div_start    = 1'b0;
        div_dividend = DIV_W'(cur.sum);
        div_divisor  = DVS_W'(n_reg);
        sqrt_start   = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                ch_next = CH_RED;
                if (start)
                begin
                    st_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                div_start = 1'b1;
                st_next   = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    m_next = empty ? '0 : div_quo[SAMPLE_BITS-1:0];
                    if (few)
                    begin
                        var_next = '0;
                        sd_next  = '0;
                        st_next  = ST_OUT;
                    end
                    else
                    begin
                        st_next = ST_PROD;
                    end
                end
            end
            ST_PROD:
            begin
                p1_next = 32'(m_reg) * 32'(cur.sum);
                p2_next = 16'(m_reg) * 16'(m_reg);
                st_next = ST_QSUM;
            end
            ST_QSUM:
            begin
                p3_next = 33'(p2_reg) * 33'(n_reg);
                qa_next = Q_W'(cur.sq) - Q_W'({p1_reg, 1'b0});
                st_next = ST_QFIN;
            end
            ST_QFIN:
            begin
                q_next  = qa_reg + Q_W'(p3_reg);
                st_next = ST_VAR;
            end
            ST_VAR:
            begin
                div_start    = 1'b1;
                div_dividend = {q_reg, 16'b0};
                div_divisor  = DVS_W'(n_reg - 1'b1);
                st_next      = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:
            begin
                if (div_done)
                begin
                    var_next   = div_quo[VAR_W+7:8];
                    sqrt_start = 1'b1;
                    st_next    = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    sd_next = sqrt_root[SD_W-1:0];
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (ch_reg == CH_BLUE)
                    begin
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                        st_next = ST_MEAN;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ch_reg <= CH_RED;
        end
        else
        begin
            st_reg <= st_next;
            ch_reg <= ch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start)
        begin
            snap_reg[0] <= stat_r;
            snap_reg[1] <= stat_g;
            snap_reg[2] <= stat_b;
            n_reg       <= count;
            drop_reg    <= dropped;
        end
        m_reg   <= m_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        p3_reg  <= p3_next;
        qa_reg  <= qa_next;
        q_reg   <= q_next;
        var_reg <= var_next;
        sd_reg  <= sd_next;
    end

    assign idle         = st_reg == ST_IDLE;
    assign out_valid    = st_reg == ST_OUT;
    assign channel      = ch_reg;
    assign mean         = m_reg;
    assign minimum      = empty ? '0 : cur.mn;
    assign maximum      = empty ? '0 : cur.mx;
    assign spread       = maximum - minimum;
    assign variance_fx  = var_reg;
    assign std_dev_fx   = sd_reg;
    assign sample_count = n_reg;
    assign too_few      = few;
    assign overflowed   = drop_reg;
    assign end_of_set   = ch_reg == CH_BLUE;

endmodule

// ----- rtl/rgb_channel_statistics_top.sv -----
// RGB channel statistics.
// Input channel: in_valid/in_ready carry one RGB sample per item, with last
// marking the final sample of a set. Samples accumulate one per cycle while
// in_ready is high, in three parallel lanes (sum, sum of squares, min, max)
// and a shared sample count. Samples beyond the maximum count are dropped
// and flagged. The item carrying last closes the set; three result items
// follow on out_valid/out_ready: red, green, then blue with end_of_set high.
// Each result runs a 50-step shared serial divider for the mean, the product
// states ST_PROD, ST_QSUM and ST_QFIN, a second 50-step divide for the
// variance and a 25-step square root. With fewer than two samples a channel
// skips the variance and square root and reports both as zero. in_ready is
// low while the set is being finished and returns the cycle after the blue
// result is taken; within a set throughput is one sample per cycle.
// A stalled receiver holds the current result and delays the rest of the set.
// Reset clears all accumulators and the result sequencer.
`include "assert_macros.svh"
module rgb_channel_statistics_top
    import rcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             channel,
    output logic [7:0]             mean,
    output logic [7:0]             minimum,
    output logic [7:0]             maximum,
    output logic [7:0]             spread,
    output logic [VAR_W-1:0]       variance_fx,
    output logic [SD_W-1:0]        std_dev_fx,
    output logic [CNT_W-1:0]       sample_count,
    output logic                   too_few,
    output logic                   overflowed,
    output logic                   end_of_set
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             accept;
    logic             full;
    logic             en;
    logic             first;
    logic             close;
    logic             post_idle;
    lane_stat_t       stat_r, stat_g, stat_b;

    assign in_ready = post_idle;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == CNT_W'(MAX_SAMPLES);
    assign en       = accept && !full;
    assign first    = count_reg == '0;
    assign close    = accept && last;

    always_comb
    begin
        count_next   = en ? count_reg + 1'b1 : count_reg;
        dropped_next = dropped_reg || (accept && full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (close)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    rcs_lane u_lane_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .first     (first),
        .clear     (close),
        .sample    (red[SAMPLE_BITS-1:0]),
        .stat_next (stat_r)
    );

    rcs_lane u_lane_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .first     (first),
        .clear     (close),
        .sample    (green[SAMPLE_BITS-1:0]),
        .stat_next (stat_g)
    );

    rcs_lane u_lane_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .first     (first),
        .clear     (close),
        .sample    (blue[SAMPLE_BITS-1:0]),
        .stat_next (stat_b)
    );

    rcs_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (close),
        .stat_r       (stat_r),
        .stat_g       (stat_g),
        .stat_b       (stat_b),
        .count        (count_next),
        .dropped      (dropped_next),
        .idle         (post_idle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .channel      (channel),
        .mean         (mean),
        .minimum      (minimum),
        .maximum      (maximum),
        .spread       (spread),
        .variance_fx  (variance_fx),
        .std_dev_fx   (std_dev_fx),
        .sample_count (sample_count),
        .too_few      (too_few),
        .overflowed   (overflowed),
        .end_of_set   (end_of_set)
    );

    `RCS_ASSERT(a_out_blocks_in, !(out_valid && in_ready))
    `RCS_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_SAMPLES))
    `RCS_ASSERT_NEXT(a_last_busy, (in_valid && in_ready && last), !in_ready)
    `RCS_ASSERT_NEXT(a_last_clears, (in_valid && in_ready && last), count_reg == '0)

endmodule

// ----- tb/rgb_channel_statistics_top_test.sv -----
module rgb_channel_statistics_top_test;
    import rcs_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 last;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           channel;
    logic [7:0]           mean;
    logic [7:0]           minimum;
    logic [7:0]           maximum;
    logic [7:0]           spread;
    logic [VAR_W-1:0]     variance_fx;
    logic [SD_W-1:0]      std_dev_fx;
    logic [CNT_W-1:0]     sample_count;
    logic                 too_few;
    logic                 overflowed;
    logic                 end_of_set;

    typedef struct packed {
        logic [1:0]       channel;
        logic [7:0]       mean;
        logic [7:0]       minimum;
        logic [7:0]       maximum;
        logic [7:0]       spread;
        logic [VAR_W-1:0] variance_fx;
        logic [SD_W-1:0]  std_dev_fx;
        logic [CNT_W-1:0] sample_count;
        logic             too_few;
        logic             overflowed;
        logic             end_of_set;
    } channel_stats_t;

    channel_stats_t stats_pending[$];

    longint unsigned acc_count;
    longint unsigned acc_sum [3];
    longint unsigned acc_sq  [3];
    longint unsigned acc_min [3];
    longint unsigned acc_max [3];
    bit              acc_dropped;

    int  mismatches;
    int  samples_sent;
    int  sets_closed;
    int  results_seen;
    bit  quiet;
    int  hold_len;

    rgb_channel_statistics_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .channel      (channel),
        .mean         (mean),
        .minimum      (minimum),
        .maximum      (maximum),
        .spread       (spread),
        .variance_fx  (variance_fx),
        .std_dev_fx   (std_dev_fx),
        .sample_count (sample_count),
        .too_few      (too_few),
        .overflowed   (overflowed),
        .end_of_set   (end_of_set)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic clear_accumulators();
        acc_count = 0;
        acc_dropped = 0;
        for (int c = 0; c < 3; c++)
        begin
            acc_sum[c] = 0;
            acc_sq[c]  = 0;
            acc_min[c] = 0;
            acc_max[c] = 0;
        end
    endtask

    task automatic accumulate_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic l);
        longint unsigned v [3];
        longint unsigned n;
        longint unsigned m;
        longint unsigned q;
        longint unsigned d;
        longint unsigned q1;
        longint unsigned rm;
        channel_stats_t  e;
        v[0] = 64'(r);
        v[1] = 64'(g);
        v[2] = 64'(b);
        if (acc_count >= MAX_SAMPLES)
            acc_dropped = 1;
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (acc_count == 0)
                begin
                    acc_min[c] = v[c];
                    acc_max[c] = v[c];
                end
                else
                begin
                    if (v[c] < acc_min[c])
                        acc_min[c] = v[c];
                    if (v[c] > acc_max[c])
                        acc_max[c] = v[c];
                end
                acc_sum[c] += v[c];
                acc_sq[c]  += v[c] * v[c];
            end
            acc_count++;
        end
        if (!l)
            return;
        n = acc_count;
        for (int c = 0; c < 3; c++)
        begin
            e = '0;
            e.channel = (c == 0) ? CH_RED : (c == 1) ? CH_GREEN : CH_BLUE;
            m = 0;
            if (n != 0)
            begin
                m = acc_sum[c] / n;
                e.minimum = 8'(acc_min[c]);
                e.maximum = 8'(acc_max[c]);
            end
            e.mean = 8'(m);
            e.spread = e.maximum - e.minimum;
            e.too_few = (n < 2);
            if (n >= 2)
            begin
                q  = acc_sq[c] - 2 * m * acc_sum[c] + n * m * m;
                d  = n - 1;
                q1 = q / d;
                rm = q % d;
                e.variance_fx = VAR_W'((q1 << 8) + ((rm << 8) / d));
                e.std_dev_fx  = SD_W'(root_floor((q1 << 16) + ((rm << 16) / d)));
            end
            e.sample_count = CNT_W'(n);
            e.overflowed = acc_dropped;
            e.end_of_set = (c == 2);
            stats_pending.push_back(e);
        end
        sets_closed++;
        clear_accumulators();
    endtask

    task automatic send_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic l);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        last  <= l;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        accumulate_sample(r, g, b, l);
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (stats_pending.size() == 0);
    endtask

    task automatic send_random_set(int len, int lo, int hi);
        for (int i = 0; i < len; i++)
            send_sample(8'($urandom_range(hi, lo)), 8'($urandom_range(hi, lo)),
                        8'($urandom_range(hi, lo)), i == len - 1);
    endtask

    task automatic test_single_samples();
        send_sample(8'd0, 8'd0, 8'd0, 1'b1);
        send_sample(8'd255, 8'd128, 8'd1, 1'b1);
        go_idle();
    endtask

    task automatic test_extremes();
        send_sample(8'd0, 8'd255, 8'd0, 1'b0);
        send_sample(8'd255, 8'd0, 8'd0, 1'b1);
        send_sample(8'd255, 8'd255, 8'd255, 1'b0);
        send_sample(8'd255, 8'd255, 8'd255, 1'b0);
        send_sample(8'd255, 8'd255, 8'd255, 1'b1);
        send_sample(8'd0, 8'd255, 8'd170, 1'b0);
        send_sample(8'd255, 8'd0, 8'd85, 1'b0);
        send_sample(8'd0, 8'd255, 8'd170, 1'b0);
        send_sample(8'd1, 8'd254, 8'd85, 1'b1);
        go_idle();
    endtask

    task automatic test_quiet_set(int len);
        quiet = 1;
        send_random_set(len, 0, 255);
        quiet = 0;
        go_idle();
    endtask

    task automatic test_backpressure();
        hold_len = 3000;
        send_random_set(4, 0, 255);
        send_random_set(3, 0, 255);
        send_random_set(5, 0, 255);
        go_idle();
    endtask

    task automatic test_random_sets();
        int len;
        int lo;
        int hi;
        while (samples_sent < 330)
        begin
            case ($urandom_range(3))
                0: len = $urandom_range(2, 1);
                1, 2: len = $urandom_range(12, 2);
                default: len = $urandom_range(40, 10);
            endcase
            lo = $urandom_range(255);
            hi = $urandom_range(255, lo);
            if ($urandom_range(1))
            begin
                lo = 0;
                hi = 255;
            end
            if ($urandom_range(9) == 0)
                quiet = ~quiet;
            send_random_set(len, lo, hi);
        end
        quiet = 0;
        go_idle();
    endtask

    always @(negedge clk)
    begin
        if (hold_len != 0)
        begin
            out_ready <= 1'b0;
            hold_len = hold_len - 1;
        end
        else
            out_ready <= quiet || ($urandom_range(99) >= 11);
    end

    always @(posedge clk)
    begin
        channel_stats_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (stats_pending.size() == 0)
            begin
                $error("unexpected result on channel %0d", channel);
                mismatches++;
            end
            else
            begin
                e = stats_pending.pop_front();
                if (channel !== e.channel)
                begin
                    $error("channel exp %0d got %0d", e.channel, channel);
                    mismatches++;
                end
                if (mean !== e.mean)
                begin
                    $error("mean exp %0d got %0d", e.mean, mean);
                    mismatches++;
                end
                if (minimum !== e.minimum)
                begin
                    $error("minimum exp %0d got %0d", e.minimum, minimum);
                    mismatches++;
                end
                if (maximum !== e.maximum)
                begin
                    $error("maximum exp %0d got %0d", e.maximum, maximum);
                    mismatches++;
                end
                if (spread !== e.spread)
                begin
                    $error("spread exp %0d got %0d", e.spread, spread);
                    mismatches++;
                end
                if (variance_fx !== e.variance_fx)
                begin
                    $error("variance_fx exp %0d got %0d", e.variance_fx, variance_fx);
                    mismatches++;
                end
                if (std_dev_fx !== e.std_dev_fx)
                begin
                    $error("std_dev_fx exp %0d got %0d", e.std_dev_fx, std_dev_fx);
                    mismatches++;
                end
                if (sample_count !== e.sample_count)
                begin
                    $error("sample_count exp %0d got %0d", e.sample_count, sample_count);
                    mismatches++;
                end
                if (too_few !== e.too_few)
                begin
                    $error("too_few exp %0d got %0d", e.too_few, too_few);
                    mismatches++;
                end
                if (overflowed !== e.overflowed)
                begin
                    $error("overflowed exp %0d got %0d", e.overflowed, overflowed);
                    mismatches++;
                end
                if (end_of_set !== e.end_of_set)
                begin
                    $error("end_of_set exp %0d got %0d", e.end_of_set, end_of_set);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        red = '0;
        green = '0;
        blue = '0;
        last = 1'b0;
        mismatches = 0;
        samples_sent = 0;
        sets_closed = 0;
        results_seen = 0;
        quiet = 0;
        hold_len = 0;
        clear_accumulators();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_samples();
        test_extremes();
        test_quiet_set(40);
        test_backpressure();
        test_random_sets();

        repeat (500) @(posedge clk);
        if (stats_pending.size() != 0)
        begin
            $error("%0d results never arrived", stats_pending.size());
            mismatches++;
        end
        $display("Covered %0d samples in %0d sets, %0d results checked,",
                 samples_sent, sets_closed, results_seen);
        $display("including single-sample sets, extreme values, an unbroken set and a long stall.");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rcs_pkg.sv
rtl/rcs_lane.sv
rtl/rcs_div.sv
rtl/rcs_sqrt.sv
rtl/rcs_post.sv
rtl/rgb_channel_statistics_top.sv
tb/rgb_channel_statistics_top_test.sv
